// ===== sv/fxcrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fxcrc_pkg
// Shared types, constants and the bytewise CRC-16 update of the frame checker.
// ----------------------------------------------------------------------------
package fxcrc_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_WRONG_LEN = 3'd1,
    ERR_SHORT     = 3'd2,
    ERR_XOR       = 3'd3,
    ERR_CRC       = 3'd4
  } err_t;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_SEED        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY        = 8'd3;

  localparam logic [DATA_W-1:0] RST_EXPECTED_LENGTH = 8'h00;
  localparam logic [DATA_W-1:0] RST_XOR_SEED        = 8'h99;
  localparam logic [CRC_W-1:0]  RST_CRC_INIT        = 16'hFAAA;
  localparam logic [CRC_W-1:0]  RST_CRC_POLY        = 16'h1888;

  localparam logic [LEN_W-1:0] LEN_SAT     = 9'd256;
  localparam logic [LEN_W-1:0] LEN_MAX_OK  = 9'd255;
  localparam logic [LEN_W-1:0] LEN_MIN     = 9'd3;
  localparam logic [LEN_W-1:0] LEN_ABSORB  = 9'd2;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [DATA_W-1:0] b,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] r;
    r = crc_in ^ {b, 8'h00};
    for (int k = 0; k < DATA_W; k++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/frame_xor_crc16_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_xor_crc16_checker
// Checks byte-serial frames for length, an XOR check byte and a CRC-16 tail.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle without gaps while
// in_stall is low. A frame's result is registered once its last byte has
// passed from the input register through the bytewise CRC update into the
// result register, which holds the result while out_stall is high. While a
// held result waits, the input stalls only once the next frame's last byte
// sits in the input register. The third byte from the end must equal xor_seed
// XORed with all earlier bytes, and the last two bytes, high byte first, must
// equal the MSB-first CRC of all earlier bytes. The XOR seed and the CRC
// start value are taken at each frame start.
module frame_xor_crc16_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [fxcrc_pkg::DATA_W-1:0]         in_data_byte,
  input  wire logic                                 in_last_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_frame_ok,
  output logic [2:0]                                out_error_code,
  output logic [fxcrc_pkg::CRC_W-1:0]               out_computed_crc,
  output logic [fxcrc_pkg::LEN_W-1:0]               out_frame_length,
  input  wire logic                                 cfg_we,
  input  wire logic [fxcrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fxcrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [fxcrc_pkg::DATA_W-1:0] exp_len_r;
  logic [fxcrc_pkg::DATA_W-1:0] xor_seed_r;
  logic [fxcrc_pkg::CRC_W-1:0]  crc_init_r;
  logic [fxcrc_pkg::CRC_W-1:0]  crc_poly_r;

  logic                         s1_valid_r;
  logic [fxcrc_pkg::DATA_W-1:0] s1_data_r;
  logic                         s1_last_r;

  logic [fxcrc_pkg::LEN_W-1:0]  byte_cnt_r;
  logic [fxcrc_pkg::DATA_W-1:0] win_old_r;
  logic [fxcrc_pkg::DATA_W-1:0] win_new_r;
  logic [fxcrc_pkg::DATA_W-1:0] xor_acc_r;
  logic [fxcrc_pkg::CRC_W-1:0]  crc_acc_r;

  logic                         out_valid_r;
  logic                         out_frame_ok_r;
  fxcrc_pkg::err_t              out_err_r;
  logic [fxcrc_pkg::CRC_W-1:0]  out_crc_r;
  logic [fxcrc_pkg::LEN_W-1:0]  out_len_r;

  logic                         s1_adv;
  logic                         in_accept;
  logic [fxcrc_pkg::LEN_W-1:0]  len_nxt;
  logic [fxcrc_pkg::DATA_W-1:0] xor_nxt;
  logic [fxcrc_pkg::CRC_W-1:0]  crc_nxt;
  fxcrc_pkg::err_t              err_nxt;

  // The accumulators cover every byte except the two newest, so the XOR check
  // passes exactly when the accumulated XOR, which includes the check byte,
  // is zero.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign len_nxt = (byte_cnt_r == fxcrc_pkg::LEN_SAT) ? byte_cnt_r
                                                      : byte_cnt_r + 9'd1;

  always_comb begin
    if (byte_cnt_r == '0) begin
      xor_nxt = xor_seed_r;
      crc_nxt = crc_init_r;
    end else if (byte_cnt_r >= fxcrc_pkg::LEN_ABSORB) begin
      xor_nxt = xor_acc_r ^ win_old_r;
      crc_nxt = fxcrc_pkg::crc_byte(crc_acc_r, win_old_r, crc_poly_r);
    end else begin
      xor_nxt = xor_acc_r;
      crc_nxt = crc_acc_r;
    end
  end

  always_comb begin
    priority if (len_nxt > fxcrc_pkg::LEN_MAX_OK ||
                 (exp_len_r != '0 && len_nxt != {1'b0, exp_len_r})) begin
      err_nxt = fxcrc_pkg::ERR_WRONG_LEN;
    end else if (len_nxt < fxcrc_pkg::LEN_MIN) begin
      err_nxt = fxcrc_pkg::ERR_SHORT;
    end else if (xor_nxt != '0) begin
      err_nxt = fxcrc_pkg::ERR_XOR;
    end else if ({win_new_r, s1_data_r} != crc_nxt) begin
      err_nxt = fxcrc_pkg::ERR_CRC;
    end else begin
      err_nxt = fxcrc_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r   <= fxcrc_pkg::RST_EXPECTED_LENGTH;
      xor_seed_r  <= fxcrc_pkg::RST_XOR_SEED;
      crc_init_r  <= fxcrc_pkg::RST_CRC_INIT;
      crc_poly_r  <= fxcrc_pkg::RST_CRC_POLY;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byte_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fxcrc_pkg::CFG_EXPECTED_LENGTH: exp_len_r  <= cfg_data[fxcrc_pkg::DATA_W-1:0];
          fxcrc_pkg::CFG_XOR_SEED:        xor_seed_r <= cfg_data[fxcrc_pkg::DATA_W-1:0];
          fxcrc_pkg::CFG_CRC_INIT:        crc_init_r <= cfg_data[fxcrc_pkg::CRC_W-1:0];
          fxcrc_pkg::CFG_CRC_POLY:        crc_poly_r <= cfg_data[fxcrc_pkg::CRC_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        byte_cnt_r <= s1_last_r ? '0 : len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_adv) begin
      win_old_r <= win_new_r;
      win_new_r <= s1_data_r;
      xor_acc_r <= xor_nxt;
      crc_acc_r <= crc_nxt;
    end
    if (s1_adv && s1_last_r) begin
      out_frame_ok_r <= (err_nxt == fxcrc_pkg::ERR_NONE);
      out_err_r      <= err_nxt;
      out_crc_r      <= crc_nxt;
      out_len_r      <= len_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_ok     = out_frame_ok_r;
  assign out_error_code   = out_err_r;
  assign out_computed_crc = out_crc_r;
  assign out_frame_length = out_len_r;

endmodule
`default_nettype wire

// ===== sv/fxcrc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fxcrc_checker
// Port-level assertions for the frame checker, bound to its top level.
// ----------------------------------------------------------------------------
module fxcrc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_frame_ok,
  input wire logic [2:0]                     out_error_code,
  input wire logic [fxcrc_pkg::CRC_W-1:0]    out_computed_crc,
  input wire logic [fxcrc_pkg::LEN_W-1:0]    out_frame_length
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_error_code) &&
      $stable(out_computed_crc) && $stable(out_frame_length))
    else $error("stalled result changed");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_ok == (out_error_code == fxcrc_pkg::ERR_NONE))
    else $error("frame_ok disagrees with error_code");

  a_long_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_length > fxcrc_pkg::LEN_MAX_OK |->
      out_error_code == fxcrc_pkg::ERR_WRONG_LEN)
    else $error("long frame not reported as wrong length");

  a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_length < fxcrc_pkg::LEN_MIN |->
      out_error_code == fxcrc_pkg::ERR_WRONG_LEN ||
      out_error_code == fxcrc_pkg::ERR_SHORT)
    else $error("short frame passed the length checks");

endmodule

bind frame_xor_crc16_checker fxcrc_checker u_fxcrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_ok     (out_frame_ok),
  .out_error_code   (out_error_code),
  .out_computed_crc (out_computed_crc),
  .out_frame_length (out_frame_length)
);
`default_nettype wire

// ===== tb/sv/fxcrc_frame_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fxcrc_frame_monitor
// Watches the byte, result and register ports of the frame checker. It keeps
// its own copy of the registers and of the frame state. For every frame it
// works out the verdict, the CRC and the length, and compares them field by
// field with the results that the block hands out, in order.
// ----------------------------------------------------------------------------
module fxcrc_frame_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [fxcrc_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                             in_last_byte,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_frame_ok,
  input  logic [2:0]                       out_error_code,
  input  logic [fxcrc_pkg::CRC_W-1:0]      out_computed_crc,
  input  logic [fxcrc_pkg::LEN_W-1:0]      out_frame_length,
  input  logic                             cfg_we,
  input  logic [fxcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fxcrc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                      mismatches,
  output int unsigned                      pending
);

  typedef struct packed {
    logic                        ok;
    fxcrc_pkg::err_t             code;
    logic [fxcrc_pkg::CRC_W-1:0] crc;
    logic [fxcrc_pkg::LEN_W-1:0] len;
  } frame_verdict_t;

  frame_verdict_t frame_verdicts[$];

  logic [7:0]                  need_len;
  logic [7:0]                  xor_start;
  logic [fxcrc_pkg::CRC_W-1:0] crc_start;
  logic [fxcrc_pkg::CRC_W-1:0] crc_gen;

  logic [7:0]                  tail [0:2];
  logic [fxcrc_pkg::LEN_W-1:0] byte_cnt;
  logic [7:0]                  xor_sum;
  logic [fxcrc_pkg::CRC_W-1:0] crc_sum;

  function automatic logic [fxcrc_pkg::CRC_W-1:0] crc16_msb_step(
      input logic [fxcrc_pkg::CRC_W-1:0] acc, input logic [7:0] b);
    logic [fxcrc_pkg::CRC_W-1:0] r;
    r = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[fxcrc_pkg::CRC_W-1] ? ({r[fxcrc_pkg::CRC_W-2:0], 1'b0} ^ crc_gen)
                                : {r[fxcrc_pkg::CRC_W-2:0], 1'b0};
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
  endtask

  task automatic clear_frame();
    tail[0] = 8'h00;
    tail[1] = 8'h00;
    tail[2] = 8'h00;
    byte_cnt = '0;
    xor_sum = xor_start;
    crc_sum = crc_start;
  endtask

  always @(posedge clk) begin : track
    frame_verdict_t want;
    logic [fxcrc_pkg::CRC_W-1:0] crc_now;
    if (!rst_n) begin
      mismatches = 0;
      need_len = fxcrc_pkg::RST_EXPECTED_LENGTH;
      xor_start = fxcrc_pkg::RST_XOR_SEED;
      crc_start = fxcrc_pkg::RST_CRC_INIT;
      crc_gen = fxcrc_pkg::RST_CRC_POLY;
      clear_frame();
      frame_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fxcrc_pkg::CFG_EXPECTED_LENGTH: need_len = cfg_data[7:0];
          fxcrc_pkg::CFG_XOR_SEED:        xor_start = cfg_data[7:0];
          fxcrc_pkg::CFG_CRC_INIT:        crc_start = cfg_data;
          fxcrc_pkg::CFG_CRC_POLY:        crc_gen = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (frame_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none actual code %0h crc %0h length %0d",
                   $time, out_error_code, out_computed_crc, out_frame_length);
        end else begin
          want = frame_verdicts.pop_front();
          if (want.ok !== out_frame_ok)
            flag_mismatch("frame_ok", 16'(want.ok), 16'(out_frame_ok));
          if (want.code !== out_error_code)
            flag_mismatch("error_code", 16'(want.code), 16'(out_error_code));
          if (want.crc !== out_computed_crc)
            flag_mismatch("computed_crc", want.crc, out_computed_crc);
          if (want.len !== out_frame_length)
            flag_mismatch("frame_length", 16'(want.len), 16'(out_frame_length));
        end
      end

      if (in_valid && !in_stall) begin
        if (byte_cnt == 0) begin
          xor_sum = xor_start;
          crc_sum = crc_start;
        end
        if (byte_cnt >= 3) begin
          xor_sum = xor_sum ^ tail[0];
          crc_sum = crc16_msb_step(crc_sum, tail[0]);
        end
        tail[0] = tail[1];
        tail[1] = tail[2];
        tail[2] = in_data_byte;
        if (byte_cnt < fxcrc_pkg::LEN_SAT) byte_cnt = byte_cnt + 1'b1;

        if (in_last_byte) begin
          crc_now = (byte_cnt >= 3) ? crc16_msb_step(crc_sum, tail[0]) : crc_sum;
          if (byte_cnt > fxcrc_pkg::LEN_MAX_OK ||
              (need_len != 0 && byte_cnt != {1'b0, need_len}))
            want.code = fxcrc_pkg::ERR_WRONG_LEN;
          else if (byte_cnt < fxcrc_pkg::LEN_MIN)
            want.code = fxcrc_pkg::ERR_SHORT;
          else if (tail[0] != xor_sum)
            want.code = fxcrc_pkg::ERR_XOR;
          else if ({tail[1], tail[2]} != crc_now)
            want.code = fxcrc_pkg::ERR_CRC;
          else
            want.code = fxcrc_pkg::ERR_NONE;
          want.ok = (want.code == fxcrc_pkg::ERR_NONE);
          want.crc = crc_now;
          want.len = byte_cnt;
          frame_verdicts.push_back(want);
          clear_frame();
        end
      end
    end
    pending = frame_verdicts.size();
  end

endmodule

// ===== tb/sv/tb_frame_xor_crc16_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_xor_crc16_checker
// Sends byte frames to the frame checker: first a few short hand-picked frames,
// then phases of random frames under changing register settings, many well
// formed, others with a damaged check byte, CRC, body or length, or noise.
// Both sides idle at random in most phases. A monitor predicts every result.
// ----------------------------------------------------------------------------
module tb_frame_xor_crc16_checker;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES = 216;

  typedef enum {BODY_RANDOM, BODY_ZERO, BODY_ONES} body_fill_t;
  typedef enum {DAMAGE_NONE, DAMAGE_XOR, DAMAGE_CRC, DAMAGE_BODY, DAMAGE_NOISE} damage_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [fxcrc_pkg::DATA_W-1:0]     in_data_byte = '0;
  logic                             in_last_byte = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_frame_ok;
  logic [2:0]                       out_error_code;
  logic [fxcrc_pkg::CRC_W-1:0]      out_computed_crc;
  logic [fxcrc_pkg::LEN_W-1:0]      out_frame_length;
  logic                             cfg_we = 1'b0;
  logic [fxcrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fxcrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  logic        in_idle_en = 1'b1;
  logic        out_idle_en = 1'b1;

  logic [7:0]                  len_cur = fxcrc_pkg::RST_EXPECTED_LENGTH;
  logic [7:0]                  seed_cur = fxcrc_pkg::RST_XOR_SEED;
  logic [fxcrc_pkg::CRC_W-1:0] init_cur = fxcrc_pkg::RST_CRC_INIT;
  logic [fxcrc_pkg::CRC_W-1:0] poly_cur = fxcrc_pkg::RST_CRC_POLY;
  logic [7:0]                  frame_buf[$];

  frame_xor_crc16_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_ok     (out_frame_ok),
    .out_error_code   (out_error_code),
    .out_computed_crc (out_computed_crc),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  fxcrc_frame_monitor u_frame_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_ok     (out_frame_ok),
    .out_error_code   (out_error_code),
    .out_computed_crc (out_computed_crc),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin : result_backpressure
    int unsigned n;
    if (!rst_n) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n = out_idle_en ? $urandom_range(0, 9) : 0;
      end else if (stall_left != 0) begin
        n = stall_left - 1;
      end else begin
        n = 0;
      end
      stall_left <= n;
      out_stall <= (n != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = in_idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic make_frame(input int len, input body_fill_t fill);
    logic [7:0]                  b;
    logic [7:0]                  chk;
    logic [fxcrc_pkg::CRC_W-1:0] crc;
    frame_buf.delete();
    chk = seed_cur;
    crc = init_cur;
    for (int i = 0; i < len; i++) begin
      if (len < 3 || i < len - 3) begin
        case (fill)
          BODY_ZERO: b = 8'h00;
          BODY_ONES: b = 8'hFF;
          default:   b = 8'($urandom_range(0, 255));
        endcase
        chk = chk ^ b;
        crc = fxcrc_pkg::crc_byte(crc, b, poly_cur);
      end else if (i == len - 3) begin
        b = chk;
        crc = fxcrc_pkg::crc_byte(crc, b, poly_cur);
      end else if (i == len - 2) begin
        b = crc[15:8];
      end else begin
        b = crc[7:0];
      end
      frame_buf.push_back(b);
    end
  endtask

  task automatic damage_frame(input damage_t kind);
    int unsigned n;
    logic [7:0]  mask;
    n = frame_buf.size();
    mask = 8'h01 << $urandom_range(0, 7);
    case (kind)
      DAMAGE_XOR:   if (n >= 3) frame_buf[n-3] ^= mask;
      DAMAGE_CRC:   if (n >= 3) frame_buf[$urandom_range(n - 2, n - 1)] ^= mask;
      DAMAGE_BODY:  if (n > 3) frame_buf[$urandom_range(0, n - 4)] ^= mask;
      DAMAGE_NOISE: foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endtask

  function automatic int pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (len_cur != 0 && r < 70) return int'(len_cur);
    if (r < 76) return $urandom_range(1, 2);
    if (r < 79) return $urandom_range(250, 300);
    return $urandom_range(3, 16);
  endfunction

  function automatic damage_t pick_damage();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return DAMAGE_NONE;
    if (r < 65) return DAMAGE_XOR;
    if (r < 75) return DAMAGE_CRC;
    if (r < 85) return DAMAGE_BODY;
    return DAMAGE_NOISE;
  endfunction

  task automatic reg_write(input logic [fxcrc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fxcrc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] len, input logic [7:0] seed,
                              input logic [fxcrc_pkg::CRC_W-1:0] init,
                              input logic [fxcrc_pkg::CRC_W-1:0] poly);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    reg_write(fxcrc_pkg::CFG_EXPECTED_LENGTH, {junk, len});
    junk = 8'($urandom_range(0, 255));
    reg_write(fxcrc_pkg::CFG_XOR_SEED, {junk, seed});
    reg_write(fxcrc_pkg::CFG_CRC_INIT, init);
    reg_write(fxcrc_pkg::CFG_CRC_POLY, poly);
    reg_write(8'($urandom_range(int'(fxcrc_pkg::CFG_CRC_POLY) + 1, 255)),
              16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    len_cur = len;
    seed_cur = seed;
    init_cur = init;
    poly_cur = poly;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    make_frame(1, BODY_ONES);
    send_frame();
    make_frame(2, BODY_ZERO);
    send_frame();
    make_frame(3, BODY_RANDOM);
    send_frame();
    make_frame(3, BODY_RANDOM);
    damage_frame(DAMAGE_XOR);
    send_frame();
    make_frame(4, BODY_ONES);
    send_frame();
    make_frame(4, BODY_ZERO);
    damage_frame(DAMAGE_CRC);
    send_frame();
    settle();
    program_regs(8'd3, fxcrc_pkg::RST_XOR_SEED, fxcrc_pkg::RST_CRC_INIT,
                 fxcrc_pkg::RST_CRC_POLY);
    make_frame(3, BODY_RANDOM);
    send_frame();
    make_frame(2, BODY_RANDOM);
    send_frame();

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: program_regs(8'd0, 8'h00, 16'h0000, 16'h0000);
        1: program_regs(8'd0, 8'hFF, 16'hFFFF, 16'hFFFF);
        2: program_regs(8'd255, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
        3: program_regs(8'($urandom_range(3, 12)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        4: program_regs(8'($urandom_range(1, 2)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        7: program_regs(fxcrc_pkg::RST_EXPECTED_LENGTH, fxcrc_pkg::RST_XOR_SEED,
                        fxcrc_pkg::RST_CRC_INIT, fxcrc_pkg::RST_CRC_POLY);
        default: program_regs(8'd0, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
      endcase
      in_idle_en = (phase != 1) && (phase != 4);
      out_idle_en <= (phase != 1);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        make_frame(pick_length(), BODY_RANDOM);
        damage_frame(pick_damage());
        send_frame();
        sent += frame_buf.size();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
